@@ sv/tblm_pkg.sv @@
// Package with the shared types, constants and tables of the blob layout matcher.
package tblm_pkg;

  localparam int INDEX_COUNT = 256;
  localparam int LAYOUT_POINTS = 3;
  localparam int PERM_COUNT = 6;
  localparam int ADDR_W = 5;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_FRAME_END = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [2:0] REG_POINT_A = 3'd0;
  localparam logic [2:0] REG_POINT_B = 3'd1;
  localparam logic [2:0] REG_POINT_C = 3'd2;
  localparam logic [2:0] REG_MIN_AREA = 3'd3;
  localparam logic [2:0] REG_MAX_AREA = 3'd4;
  localparam logic [2:0] REG_YOUNG_LIMIT = 3'd5;
  localparam logic [2:0] REG_OLD_LIMIT = 3'd6;

  localparam logic [19:0] ERROR_MAX = 20'hFFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] PERM_TABLE [0:5][0:2] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
  };

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] blob_index;
    logic [8:0] blob_x;
    logic [7:0] blob_y;
    logic [8:0] blob_width;
    logic [7:0] blob_height;
    logic [7:0] blob_age;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        layout_valid;
    logic [19:0] layout_error;
  } out_word_t;

  typedef struct packed {
    logic [17:0] template_point_a;
    logic [17:0] template_point_b;
    logic [17:0] template_point_c;
    logic [16:0] min_area;
    logic [16:0] max_area;
    logic [7:0]  young_limit;
    logic [7:0]  old_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  max_age;
    logic [31:0] sum_x;
    logic [31:0] sum_y;
    logic [15:0] count;
  } entry_t;

endpackage

@@ sv/tracked_blob_layout_matcher.sv @@
// An observation passes a check state and, if stored, an update state before its result; clear and
// no-op go straight to the result. The next word is taken only after the result word is handed on.
// End of frame sweeps the whole table, then divides sum by count for the averages of each old entry,
// squares the distance terms for each template pairing, tries all six permutations and issues
// the result, which follows the sweep at once when fewer than two old entries exist.
// Synchronous reset clears control and marks all entries invalid, unseen.
module tracked_blob_layout_matcher #(
  parameter int INDEX_COUNT = tblm_pkg::INDEX_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tblm_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tblm_pkg::out_word_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tblm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IW = $clog2(INDEX_COUNT);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OBS_CHK = 4'd1;
  localparam logic [3:0] S_OBS_UPD = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_DIV_LD = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_SQ = 4'd6;
  localparam logic [3:0] S_PERM = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  tblm_pkg::cfg_t      cfg;
  tblm_pkg::in_word_t  item;
  tblm_pkg::out_word_t res;
  tblm_pkg::entry_t    rdata;
  tblm_pkg::entry_t    wdata;

  logic [3:0]             state;
  logic [INDEX_COUNT-1:0] valid_bits;
  logic [INDEX_COUNT-1:0] seen_bits;
  logic [IW:0]            cnt;
  logic                   p_go;
  logic                   p_keep;
  logic [1:0]             n;
  logic [31:0]            ent_sx [3];
  logic [31:0]            ent_sy [3];
  logic [15:0]            ent_cnt [3];
  logic [8:0]             avg_x [3];
  logic [8:0]             avg_y [3];
  logic [1:0]             sel;
  logic                   coord;
  logic [3:0]             k;
  logic [31:0]            rem;
  logic [8:0]             quo;
  logic [1:0]             sq_a;
  logic [1:0]             sq_k;
  logic                   sq_ph;
  logic [17:0]            sq_x;
  logic [18:0]            d [3][3];
  logic [2:0]             perm_p;
  logic [20:0]            best;

  logic [IW-1:0]          raddr;
  logic [IW-1:0]          widx;
  logic [IW-1:0]          ci;
  logic                   we;
  logic [16:0]            area;
  logic                   pass;
  logic [39:0]            dvs;
  logic                   qbit;
  logic [8:0]             q_next;
  logic [8:0]             tx [3];
  logic [8:0]             ty [3];
  logic [8:0]             op_a;
  logic [8:0]             op_b;
  logic [8:0]             diff;
  logic [17:0]            prod;
  logic [20:0]            psum;
  logic [20:0]            best_n;

  tblm_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  tblm_table #(.DEPTH(INDEX_COUNT), .AW(IW)) u_table (
    .clk(clk), .we(we), .waddr(widx), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign widx = item.blob_index[IW-1:0];
  assign ci = cnt[IW-1:0];
  assign raddr = (state == S_SWEEP) ? ci : widx;
  assign area = 17'(item.blob_width) * 17'(item.blob_height);
  assign pass = (32'(item.blob_index) < INDEX_COUNT) && (cfg.min_area < area)
                && (area < cfg.max_area) && (cfg.young_limit < item.blob_age);

  assign tx[0] = cfg.template_point_a[17:9];
  assign ty[0] = cfg.template_point_a[8:0];
  assign tx[1] = cfg.template_point_b[17:9];
  assign ty[1] = cfg.template_point_b[8:0];
  assign tx[2] = cfg.template_point_c[17:9];
  assign ty[2] = cfg.template_point_c[8:0];

  always_comb begin
    we = 1'b0;
    wdata = rdata;
    if (state == S_OBS_UPD) begin
      if (!valid_bits[widx]) begin
        we = 1'b1;
        wdata.max_age = item.blob_age;
        wdata.sum_x = 32'(item.blob_x);
        wdata.sum_y = 32'(item.blob_y);
        wdata.count = 16'd1;
      end else if (item.blob_age >= rdata.max_age) begin
        we = 1'b1;
        wdata.max_age = item.blob_age;
        if (rdata.count != tblm_pkg::COUNT_MAX) begin
          wdata.sum_x = rdata.sum_x + 32'(item.blob_x);
          wdata.sum_y = rdata.sum_y + 32'(item.blob_y);
          wdata.count = rdata.count + 16'd1;
        end
      end
    end
  end

  // Shared divider step: one quotient bit per cycle, quotient known to fit nine bits.
  always_comb begin
    dvs = 40'(ent_cnt[sel]) << k;
    qbit = (40'(rem) >= dvs);
    q_next = quo | (9'(qbit) << k);
  end

  // Shared squarer for the distance terms.
  always_comb begin
    op_a = sq_ph ? ty[sq_a] : tx[sq_a];
    op_b = sq_ph ? avg_y[sq_k] : avg_x[sq_k];
    diff = (op_a > op_b) ? op_a - op_b : op_b - op_a;
    prod = 18'(diff) * 18'(diff);
  end

  always_comb begin
    psum = 21'd0;
    for (int a = 0; a < tblm_pkg::LAYOUT_POINTS; a++) begin
      if (tblm_pkg::PERM_TABLE[perm_p][a] < n) begin
        psum = psum + 21'(d[a][tblm_pkg::PERM_TABLE[perm_p][a]]);
      end
    end
    best_n = (psum < best) ? psum : best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid_bits <= '0;
      seen_bits <= '0;
      p_go <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            res <= '0;
            case (in_data.opcode)
              tblm_pkg::OP_OBSERVE: state <= S_OBS_CHK;
              tblm_pkg::OP_FRAME_END: begin
                cnt <= '0;
                p_go <= 1'b0;
                n <= 2'd0;
                state <= S_SWEEP;
              end
              tblm_pkg::OP_CLEAR: begin
                valid_bits <= '0;
                seen_bits <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_OBS_CHK: begin
          state <= pass ? S_OBS_UPD : S_DONE;
        end
        S_OBS_UPD: begin
          valid_bits[widx] <= 1'b1;
          seen_bits[widx] <= 1'b1;
          res.accepted <= 1'b1;
          state <= S_DONE;
        end
        S_SWEEP: begin
          if (32'(cnt) < INDEX_COUNT) begin
            p_keep <= valid_bits[ci] & seen_bits[ci];
            valid_bits[ci] <= valid_bits[ci] & seen_bits[ci];
            seen_bits[ci] <= 1'b0;
            p_go <= 1'b1;
            cnt <= cnt + 1'b1;
          end else begin
            p_go <= 1'b0;
          end
          if (p_go && p_keep && n < 2'd3 && rdata.max_age > cfg.old_limit) begin
            ent_sx[n] <= rdata.sum_x;
            ent_sy[n] <= rdata.sum_y;
            ent_cnt[n] <= rdata.count;
            n <= n + 2'd1;
          end
          if (!(32'(cnt) < INDEX_COUNT) && !p_go) begin
            if (n < 2'd2) begin
              res.layout_error <= tblm_pkg::ERROR_MAX;
              state <= S_DONE;
            end else begin
              sel <= 2'd0;
              coord <= 1'b0;
              state <= S_DIV_LD;
            end
          end
        end
        S_DIV_LD: begin
          rem <= coord ? ent_sy[sel] : ent_sx[sel];
          quo <= 9'd0;
          k <= 4'd8;
          state <= S_DIV;
        end
        S_DIV: begin
          if (qbit) begin
            rem <= rem - dvs[31:0];
          end
          quo <= q_next;
          if (k == 4'd0) begin
            if (coord) begin
              avg_y[sel] <= q_next;
            end else begin
              avg_x[sel] <= q_next;
            end
            coord <= !coord;
            if (coord && !(sel + 2'd1 < n)) begin
              sq_a <= 2'd0;
              sq_k <= 2'd0;
              sq_ph <= 1'b0;
              state <= S_SQ;
            end else begin
              state <= S_DIV_LD;
              if (coord) begin
                sel <= sel + 2'd1;
              end
            end
          end else begin
            k <= k - 4'd1;
          end
        end
        S_SQ: begin
          sq_ph <= !sq_ph;
          if (!sq_ph) begin
            sq_x <= prod;
          end else begin
            d[sq_a][sq_k] <= 19'(sq_x) + 19'(prod);
            if (sq_k + 2'd1 < n) begin
              sq_k <= sq_k + 2'd1;
            end else begin
              sq_k <= 2'd0;
              if (sq_a == 2'd2) begin
                perm_p <= 3'd0;
                best <= '1;
                state <= S_PERM;
              end else begin
                sq_a <= sq_a + 2'd1;
              end
            end
          end
        end
        S_PERM: begin
          best <= best_n;
          if (32'(perm_p) == tblm_pkg::PERM_COUNT - 1) begin
            res.layout_valid <= 1'b1;
            res.layout_error <= (best_n > 21'(tblm_pkg::ERROR_MAX)) ?
                                tblm_pkg::ERROR_MAX : best_n[19:0];
            state <= S_DONE;
          end else begin
            perm_p <= perm_p + 3'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data <= res;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/tblm_regs.sv @@
// Configuration register file with its APB-style access port.
module tblm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tblm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tblm_pkg::cfg_t              cfg
);

  logic [2:0] reg_sel;

  assign reg_sel = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.template_point_a <= 18'd85128;
      cfg.template_point_b <= 18'd118363;
      cfg.template_point_c <= 18'd25679;
      cfg.min_area <= 17'd40;
      cfg.max_area <= 17'd131071;
      cfg.young_limit <= 8'd0;
      cfg.old_limit <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        tblm_pkg::REG_POINT_A: cfg.template_point_a <= pwdata[17:0];
        tblm_pkg::REG_POINT_B: cfg.template_point_b <= pwdata[17:0];
        tblm_pkg::REG_POINT_C: cfg.template_point_c <= pwdata[17:0];
        tblm_pkg::REG_MIN_AREA: cfg.min_area <= pwdata[16:0];
        tblm_pkg::REG_MAX_AREA: cfg.max_area <= pwdata[16:0];
        tblm_pkg::REG_YOUNG_LIMIT: cfg.young_limit <= pwdata[7:0];
        tblm_pkg::REG_OLD_LIMIT: cfg.old_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tblm_pkg::REG_POINT_A: prdata = 32'(cfg.template_point_a);
      tblm_pkg::REG_POINT_B: prdata = 32'(cfg.template_point_b);
      tblm_pkg::REG_POINT_C: prdata = 32'(cfg.template_point_c);
      tblm_pkg::REG_MIN_AREA: prdata = 32'(cfg.min_area);
      tblm_pkg::REG_MAX_AREA: prdata = 32'(cfg.max_area);
      tblm_pkg::REG_YOUNG_LIMIT: prdata = 32'(cfg.young_limit);
      tblm_pkg::REG_OLD_LIMIT: prdata = 32'(cfg.old_limit);
      default: prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/tblm_table.sv @@
// Blob entry memory with one write port and one registered read port.
module tblm_table #(
  parameter int DEPTH = tblm_pkg::INDEX_COUNT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  tblm_pkg::entry_t      wdata,
  input  logic [AW-1:0]         raddr,
  output tblm_pkg::entry_t      rdata
);

  tblm_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tblm_checker.sv @@
// Port-level checker for the blob layout matcher and its bind to the top level.
module tblm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tblm_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result word changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Block not idle after reset.");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> !out_data.layout_valid && out_data.layout_error == 20'd0)
    else $error("Observation result carries layout fields.");

  a_invalid_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.layout_valid |->
      out_data.layout_error == 20'd0 || out_data.layout_error == tblm_pkg::ERROR_MAX)
    else $error("Invalid layout with unexpected error value.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Word accepted while previous word in work.");

endmodule

bind tracked_blob_layout_matcher tblm_checker u_tblm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the tracked blob layout matcher.
`timescale 1ns / 1ps

class layout_scoreboard;
  logic [17:0] point_a, point_b, point_c;
  logic [16:0] min_area, max_area;
  logic [7:0] young_limit, old_limit;
  bit tab_valid [256];
  bit tab_seen [256];
  logic [7:0] tab_age [256];
  logic [31:0] tab_sx [256];
  logic [31:0] tab_sy [256];
  logic [15:0] tab_cnt [256];
  tblm_pkg::out_word_t pending [$];
  int errors;
  int results;
  int accepts;
  int layouts;

  function void reset_state();
    point_a = 18'd85128;
    point_b = 18'd118363;
    point_c = 18'd25679;
    min_area = 17'd40;
    max_area = 17'd131071;
    young_limit = 8'd0;
    old_limit = 8'd0;
    foreach (tab_valid[i]) begin
      tab_valid[i] = 0;
      tab_seen[i] = 0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      tblm_pkg::REG_POINT_A: point_a = v[17:0];
      tblm_pkg::REG_POINT_B: point_b = v[17:0];
      tblm_pkg::REG_POINT_C: point_c = v[17:0];
      tblm_pkg::REG_MIN_AREA: min_area = v[16:0];
      tblm_pkg::REG_MAX_AREA: max_area = v[16:0];
      tblm_pkg::REG_YOUNG_LIMIT: young_limit = v[7:0];
      tblm_pkg::REG_OLD_LIMIT: old_limit = v[7:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] sq_dist(int ax, int ay, int bx, int by);
    int dx, dy;
    dx = ax > bx ? ax - bx : bx - ax;
    dy = ay > by ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  function void note_input(tblm_pkg::in_word_t w);
    tblm_pkg::out_word_t r;
    int area, n, c;
    int ex [3];
    int ey [3];
    int tx [3];
    int ty [3];
    logic [31:0] best, sum;
    r = '0;
    case (w.opcode)
      tblm_pkg::OP_OBSERVE: begin
        area = int'(w.blob_width) * int'(w.blob_height);
        if (min_area < area && area < max_area && young_limit < w.blob_age) begin
          if (!tab_valid[w.blob_index]) begin
            tab_valid[w.blob_index] = 1;
            tab_age[w.blob_index] = w.blob_age;
            tab_sx[w.blob_index] = w.blob_x;
            tab_sy[w.blob_index] = w.blob_y;
            tab_cnt[w.blob_index] = 1;
          end else if (w.blob_age >= tab_age[w.blob_index]) begin
            tab_age[w.blob_index] = w.blob_age;
            if (tab_cnt[w.blob_index] != tblm_pkg::COUNT_MAX) begin
              tab_sx[w.blob_index] += w.blob_x;
              tab_sy[w.blob_index] += w.blob_y;
              tab_cnt[w.blob_index] += 1;
            end
          end
          tab_seen[w.blob_index] = 1;
          r.accepted = 1;
          accepts++;
        end
      end
      tblm_pkg::OP_FRAME_END: begin
        n = 0;
        for (int i = 0; i < 256; i++) begin
          if (tab_valid[i] && !tab_seen[i]) tab_valid[i] = 0;
          tab_seen[i] = 0;
          if (tab_valid[i] && n < 3 && old_limit < tab_age[i]) begin
            c = tab_cnt[i] == 0 ? 1 : tab_cnt[i];
            ex[n] = tab_sx[i] / c;
            ey[n] = tab_sy[i] / c;
            n++;
          end
        end
        if (n < 2) begin
          r.layout_error = tblm_pkg::ERROR_MAX;
        end else begin
          tx[0] = point_a[17:9]; ty[0] = point_a[8:0];
          tx[1] = point_b[17:9]; ty[1] = point_b[8:0];
          tx[2] = point_c[17:9]; ty[2] = point_c[8:0];
          best = 32'hFFFFFFFF;
          for (int p = 0; p < 6; p++) begin
            sum = 0;
            for (int a = 0; a < 3; a++) begin
              c = tblm_pkg::PERM_TABLE[p][a];
              if (c < n) sum += sq_dist(tx[a], ty[a], ex[c], ey[c]);
            end
            if (sum < best) best = sum;
          end
          r.layout_valid = 1;
          r.layout_error = best > tblm_pkg::ERROR_MAX ? tblm_pkg::ERROR_MAX : best[19:0];
          layouts++;
        end
      end
      tblm_pkg::OP_CLEAR: begin
        foreach (tab_valid[i]) begin
          tab_valid[i] = 0;
          tab_seen[i] = 0;
        end
      end
      default: ;
    endcase
    pending = {pending, r};
  endfunction

  function void check_result(tblm_pkg::out_word_t got);
    tblm_pkg::out_word_t want;
    results++;
    if (pending.size() == 0) begin
      report_error("result word with nothing expected", 0, got);
      return;
    end
    want = pending.pop_front();
    if (got.accepted !== want.accepted) report_error("accepted", want.accepted, got.accepted);
    if (got.layout_valid !== want.layout_valid)
      report_error("layout_valid", want.layout_valid, got.layout_valid);
    if (got.layout_error !== want.layout_error)
      report_error("layout_error", want.layout_error, got.layout_error);
  endfunction

  function void report_error(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $time);
  endfunction
endclass

module testbench;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  tblm_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  tblm_pkg::out_word_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [tblm_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  layout_scoreboard board;
  bit calm = 0;
  bit drain_hold = 0;
  int idle_cycles = 0;
  int item_count = 0;
  byte unsigned busy_index [$];

  tracked_blob_layout_matcher dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    if (!rst && in_valid && in_ready) begin
      board.note_input(in_data);
      item_count++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired at %0t", $time);
      $display("tracked_blob_layout_matcher test failed");
      $finish;
    end
  end

  initial begin : receiver
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (drain_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        drain_hold = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 17);
        out_ready <= 0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.set_reg(idx, v);
  endtask

  task automatic send(tblm_pkg::in_word_t w);
    int gap;
    if (!calm && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic tblm_pkg::in_word_t blob(byte unsigned idx, int age);
    tblm_pkg::in_word_t w;
    w.opcode = tblm_pkg::OP_OBSERVE;
    w.blob_index = idx;
    w.blob_x = $urandom;
    w.blob_y = $urandom;
    w.blob_width = $urandom_range(8, 60);
    w.blob_height = $urandom_range(8, 60);
    w.blob_age = age;
    return w;
  endfunction

  function automatic tblm_pkg::in_word_t control(logic [1:0] op);
    tblm_pkg::in_word_t w;
    w = $urandom;
    w.opcode = op;
    return w;
  endfunction

  task automatic frame_burst();
    int k;
    tblm_pkg::in_word_t w;
    if ($urandom_range(0, 3) == 0) busy_index.delete();
    while (busy_index.size() < 4) busy_index = {busy_index, 8'($urandom_range(0, 255))};
    k = $urandom_range(1, 6);
    repeat (k) begin
      w = blob(busy_index[$urandom_range(0, busy_index.size() - 1)], $urandom);
      if ($urandom_range(0, 7) == 0) w = $urandom;
      if (w.opcode == tblm_pkg::OP_FRAME_END) w.opcode = tblm_pkg::OP_OBSERVE;
      send(w);
    end
    send(control(tblm_pkg::OP_FRAME_END));
    if ($urandom_range(0, 40) == 0) send(control(tblm_pkg::OP_CLEAR));
  endtask

  initial begin : stimulus
    tblm_pkg::in_word_t w;
    board = new();
    board.reset_state();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part at reset settings.
    send(control(tblm_pkg::OP_FRAME_END));
    w = blob(8'd0, 255); w.blob_x = 0; w.blob_y = 0; send(w);
    w = blob(8'd255, 1); w.blob_x = 511; w.blob_y = 255; send(w);
    w = blob(8'd255, 0); send(w);
    w = blob(8'd0, 100); send(w);
    w = blob(8'd7, 5); w.blob_width = 511; w.blob_height = 255; send(w);
    w = blob(8'd7, 5); w.blob_width = 0; w.blob_height = 0; send(w);
    send(control(tblm_pkg::OP_FRAME_END));
    w = blob(8'd0, 255); send(w);
    w = blob(8'd255, 3); send(w);
    w = blob(8'd40, 9); send(w);
    send(control(tblm_pkg::OP_FRAME_END));
    w = blob(8'd40, 9); send(w);
    send(control(tblm_pkg::OP_FRAME_END));
    send(control(tblm_pkg::OP_NOP));
    w = blob(8'd12, 4); send(w);
    send(control(tblm_pkg::OP_CLEAR));
    send(control(tblm_pkg::OP_FRAME_END));
    w = $urandom; w.opcode = tblm_pkg::OP_OBSERVE; send(w);
    w = '1; w.opcode = tblm_pkg::OP_OBSERVE; send(w);

    // Update one entry many times with extreme coordinates, then report it.
    go_quiet();
    apb_write(tblm_pkg::REG_MIN_AREA, 0);
    w = blob(8'd9, 200);
    w.blob_width = 1; w.blob_height = 1; w.blob_x = 511; w.blob_y = 255;
    calm = 1;
    for (int i = 0; i < 150; i++) send(w);
    w.blob_index = 10; send(w);
    send(control(tblm_pkg::OP_FRAME_END));
    calm = 0;

    for (int phase = 0; phase < 5; phase++) begin
      go_quiet();
      case (phase)
        0: begin
          apb_write(tblm_pkg::REG_POINT_A, 0);
          apb_write(tblm_pkg::REG_POINT_B, 18'h3FFFF);
          apb_write(tblm_pkg::REG_POINT_C, $urandom);
          apb_write(tblm_pkg::REG_MIN_AREA, 0);
          apb_write(tblm_pkg::REG_MAX_AREA, 17'h1FFFF);
          apb_write(tblm_pkg::REG_YOUNG_LIMIT, 0);
          apb_write(tblm_pkg::REG_OLD_LIMIT, 0);
        end
        1: begin
          apb_write(tblm_pkg::REG_MIN_AREA, 17'h1FFFF);
          apb_write(tblm_pkg::REG_YOUNG_LIMIT, 255);
          apb_write(tblm_pkg::REG_OLD_LIMIT, 255);
        end
        2: begin
          apb_write(tblm_pkg::REG_POINT_A, $urandom);
          apb_write(tblm_pkg::REG_POINT_B, $urandom);
          apb_write(tblm_pkg::REG_POINT_C, $urandom);
          apb_write(tblm_pkg::REG_MIN_AREA, $urandom_range(0, 600));
          apb_write(tblm_pkg::REG_MAX_AREA, $urandom_range(1500, 4000));
          apb_write(tblm_pkg::REG_YOUNG_LIMIT, $urandom_range(0, 60));
          apb_write(tblm_pkg::REG_OLD_LIMIT, $urandom_range(0, 120));
        end
        3: begin
          apb_write(tblm_pkg::REG_MIN_AREA, 40);
          apb_write(tblm_pkg::REG_MAX_AREA, 0);
          apb_write(tblm_pkg::REG_YOUNG_LIMIT, 0);
          apb_write(tblm_pkg::REG_OLD_LIMIT, 0);
          drain_hold = 1;
        end
        default: begin
          apb_write(tblm_pkg::REG_MAX_AREA, 17'h1FFFF);
          apb_write(tblm_pkg::REG_OLD_LIMIT, 30);
          apb_write(tblm_pkg::REG_POINT_A, $urandom);
        end
      endcase
      for (int n = 0; n < (phase == 1 || phase == 3 ? 8 : 70); n++) frame_burst();
      if (phase == 4) begin
        calm = 1;
        for (int n = 0; n < 30; n++) frame_burst();
      end
    end

    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d input words and %0d results: %0d blobs stored, %0d valid layouts.",
             item_count, board.results, board.accepts, board.layouts);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tracked_blob_layout_matcher test passed");
    end else begin
      $display("tracked_blob_layout_matcher test failed");
    end
    $finish;
  end
endmodule
